FILE: sv/obu_unw_pkg.sv
// Shared constants, types and lookup functions of the OBU payload unwrap unit.
package obu_unw_pkg;

	// Size counter width and LEB128 limits
	localparam int LEN_BITS = 32;
	localparam int LEB_MAX  = 8;
	localparam int LEB_W    = LEB_MAX * 7;
	localparam int LEB_CW   = $clog2(LEB_MAX);
	localparam int SHAMT_W  = $clog2(LEB_W);

	// Result queue geometry
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// OBU header fields
	localparam logic [7:0] HDR_SIZE_PRESENT = 8'b0000_0010;
	localparam logic [7:0] HDR_EXTENSION    = 8'b0000_0100;
	localparam logic [7:0] HDR_TYPE_MASK    = 8'b0111_1000;
	localparam logic [7:0] HDR_FORBIDDEN    = 8'b1000_0000;
	localparam logic [3:0] FRAME_OBU_TYPE   = 4'd6;

	// Wrapper detection
	localparam logic [7:0] KEY_TAG   = 8'h10;
	localparam logic [7:0] INTER_TAG = 8'h30;

	// LEB128 byte fields
	localparam logic [7:0] LEB_DATA_MASK = 8'h7F;
	localparam logic [7:0] LEB_CONT      = 8'h80;

	// Status codes
	localparam logic [1:0] ST_FOUND     = 2'd0;
	localparam logic [1:0] ST_NOTFOUND  = 2'd1;
	localparam logic [1:0] ST_FORBIDDEN = 2'd2;
	localparam logic [1:0] ST_MALFORMED = 2'd3;

	// Parser phases
	typedef enum logic [10:0] {
		PH_HDR  = 11'b000_0000_0001,
		PH_EXT  = 11'b000_0000_0010,
		PH_LEB  = 11'b000_0000_0100,
		PH_SKIP = 11'b000_0000_1000,
		PH_M0   = 11'b000_0001_0000,
		PH_M1   = 11'b000_0010_0000,
		PH_M2   = 11'b000_0100_0000,
		PH_M3   = 11'b000_1000_0000,
		PH_M4   = 11'b001_0000_0000,
		PH_EMIT = 11'b010_0000_0000,
		PH_DONE = 11'b100_0000_0000
	} phase_t;

	// One queue entry: an optional payload byte and an optional status
	typedef struct packed {
		logic       has_pay;
		logic [7:0] pay;
		logic       has_st;
		logic [1:0] st;
	} res_entry_t;

	// Four magic bytes that follow the tag
	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		unique case (idx)
			2'd0:    m = 8'h4C;
			2'd1:    m = 8'h4B;
			2'd2:    m = 8'h45;
			default: m = 8'h50;
		endcase
		return m;
	endfunction

endpackage

FILE: sv/obu_unw_front.sv
// Front end: walks the OBU headers and sizes and classifies each byte.
module obu_unw_front import obu_unw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       last,
	output logic       wr_en,
	output res_entry_t wr_entry,
	output logic       at_hdr
);

	phase_t              ph_q, ph_d;
	logic                sized_q, sized_d;
	logic                frame_q, frame_d;
	logic [LEN_BITS-1:0] acc_q, acc_d;
	logic                ovf_q, ovf_d;
	logic [LEB_CW-1:0]   cnt_q, cnt_d;
	logic [LEN_BITS-1:0] bl_q, bl_d;
	logic [1:0]          code_q, code_d;

	logic                hdr_sized, hdr_frame;
	logic [SHAMT_W-1:0]  leb_shamt;
	logic [LEB_W-1:0]    leb_sh;
	logic [LEB_W:0]      leb_hi;
	logic [LEN_BITS-1:0] new_acc;
	logic                new_ovf;
	logic [LEN_BITS-1:0] bl_dec;
	logic                bl_dec_zero;
	logic                mag_ok;
	phase_t              mag_next;
	logic                emit;
	logic [1:0]          end_st;

	function automatic logic [1:0] end_status(input phase_t ph, input logic sized,
		input logic [1:0] code);
		logic [1:0] s;
		unique case (ph) inside
			PH_HDR:                          s = ST_NOTFOUND;
			PH_EXT, PH_LEB, PH_SKIP:         s = ST_MALFORMED;
			PH_EMIT:                         s = sized ? ST_MALFORMED : ST_FOUND;
			PH_M0, PH_M1, PH_M2, PH_M3, PH_M4: s = sized ? ST_MALFORMED : ST_NOTFOUND;
			default:                         s = code;
		endcase
		return s;
	endfunction

	assign hdr_sized = |(data_byte & HDR_SIZE_PRESENT);
	assign hdr_frame = (4'((data_byte & HDR_TYPE_MASK) >> 3) == FRAME_OBU_TYPE);

	// LEB128 group placement and overflow past the size counter
	assign leb_shamt = SHAMT_W'(cnt_q) * SHAMT_W'(7);
	assign leb_sh    = LEB_W'(data_byte & LEB_DATA_MASK) << leb_shamt;
	assign leb_hi    = {1'b0, leb_sh} >> LEN_BITS;
	assign new_acc   = acc_q | leb_sh[LEN_BITS-1:0];
	assign new_ovf   = ovf_q | (|leb_hi);

	assign bl_dec      = (bl_q != '0) ? bl_q - LEN_BITS'(1) : bl_q;
	assign bl_dec_zero = (bl_dec == '0);

	// Tag and magic byte check for the current phase
	always_comb begin
		mag_ok   = 1'b0;
		mag_next = PH_EMIT;
		unique case (ph_q)
			PH_M0: begin
				mag_ok   = (data_byte == KEY_TAG) || (data_byte == INTER_TAG);
				mag_next = PH_M1;
			end
			PH_M1: begin
				mag_ok   = (data_byte == magic_byte(2'd0));
				mag_next = PH_M2;
			end
			PH_M2: begin
				mag_ok   = (data_byte == magic_byte(2'd1));
				mag_next = PH_M3;
			end
			PH_M3: begin
				mag_ok   = (data_byte == magic_byte(2'd2));
				mag_next = PH_M4;
			end
			PH_M4: begin
				mag_ok   = (data_byte == magic_byte(2'd3));
				mag_next = PH_EMIT;
			end
			default: begin
				mag_ok   = 1'b0;
				mag_next = PH_EMIT;
			end
		endcase
	end

	always_comb begin
		ph_d    = ph_q;
		sized_d = sized_q;
		frame_d = frame_q;
		acc_d   = acc_q;
		ovf_d   = ovf_q;
		cnt_d   = cnt_q;
		bl_d    = bl_q;
		code_d  = code_q;
		emit    = 1'b0;
		unique case (ph_q) inside
			PH_HDR: begin
				sized_d = hdr_sized;
				frame_d = hdr_frame;
				if (|(data_byte & HDR_FORBIDDEN)) begin
					ph_d   = PH_DONE;
					code_d = ST_FORBIDDEN;
				end else if (|(data_byte & HDR_EXTENSION)) begin
					ph_d = PH_EXT;
				end else if (hdr_sized) begin
					acc_d = '0;
					ovf_d = 1'b0;
					cnt_d = '0;
					ph_d  = PH_LEB;
				end else begin
					bl_d = '0;
					if (hdr_frame) begin
						ph_d = PH_M0;
					end else begin
						ph_d   = PH_DONE;
						code_d = ST_NOTFOUND;
					end
				end
			end
			PH_EXT: begin
				if (sized_q) begin
					acc_d = '0;
					ovf_d = 1'b0;
					cnt_d = '0;
					ph_d  = PH_LEB;
				end else begin
					bl_d = '0;
					if (frame_q) begin
						ph_d = PH_M0;
					end else begin
						ph_d   = PH_DONE;
						code_d = ST_NOTFOUND;
					end
				end
			end
			PH_LEB: begin
				acc_d = new_acc;
				ovf_d = new_ovf;
				if (!(|(data_byte & LEB_CONT))) begin
					if (new_ovf) begin
						ph_d   = PH_DONE;
						code_d = ST_MALFORMED;
					end else begin
						bl_d = new_acc;
						if (new_acc == '0)
							ph_d = PH_HDR;
						else if (frame_q && (new_acc >= LEN_BITS'(5)))
							ph_d = PH_M0;
						else
							ph_d = PH_SKIP;
					end
				end else begin
					cnt_d = cnt_q + LEB_CW'(1);
					if (cnt_q == LEB_CW'(LEB_MAX - 1)) begin
						ph_d   = PH_DONE;
						code_d = ST_MALFORMED;
					end
				end
			end
			PH_SKIP: begin
				bl_d = bl_dec;
				if (bl_dec_zero)
					ph_d = PH_HDR;
			end
			PH_M0, PH_M1, PH_M2, PH_M3, PH_M4: begin
				if (sized_q)
					bl_d = bl_dec;
				if (!mag_ok) begin
					if (sized_q) begin
						ph_d = bl_dec_zero ? PH_HDR : PH_SKIP;
					end else begin
						ph_d   = PH_DONE;
						code_d = ST_NOTFOUND;
					end
				end else if (ph_q == PH_M4 && sized_q && bl_dec_zero) begin
					ph_d   = PH_DONE;
					code_d = ST_FOUND;
				end else begin
					ph_d = mag_next;
				end
			end
			PH_EMIT: begin
				emit = 1'b1;
				if (sized_q) begin
					bl_d = bl_dec;
					if (bl_dec_zero) begin
						ph_d   = PH_DONE;
						code_d = ST_FOUND;
					end
				end
			end
			PH_DONE: begin
				ph_d = PH_DONE;
			end
			default: begin
				ph_d = PH_HDR;
			end
		endcase
	end

	assign end_st = end_status(ph_d, sized_d, code_d);

	assign wr_en            = accept && (emit || last);
	assign wr_entry.has_pay = emit;
	assign wr_entry.pay     = data_byte;
	assign wr_entry.has_st  = last;
	assign wr_entry.st      = end_st;
	assign at_hdr           = (ph_q == PH_HDR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_HDR;
			sized_q <= 1'b0;
			frame_q <= 1'b0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			cnt_q   <= '0;
			bl_q    <= '0;
			code_q  <= ST_NOTFOUND;
		end else if (accept) begin
			if (last) begin
				ph_q    <= PH_HDR;
				sized_q <= 1'b0;
				frame_q <= 1'b0;
				acc_q   <= '0;
				ovf_q   <= 1'b0;
				cnt_q   <= '0;
				bl_q    <= '0;
				code_q  <= ST_NOTFOUND;
			end else begin
				ph_q    <= ph_d;
				sized_q <= sized_d;
				frame_q <= frame_d;
				acc_q   <= acc_d;
				ovf_q   <= ovf_d;
				cnt_q   <= cnt_d;
				bl_q    <= bl_d;
				code_q  <= code_d;
			end
		end
	end

endmodule

FILE: sv/obu_unw_back.sv
// Back end: queue of classified entries, each expanded into one or two result items.
module obu_unw_back import obu_unw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  res_entry_t wr_entry,
	output logic       q_full,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       is_status,
	output logic [1:0] status,
	output logic       end_of_run,
	output logic       split
);

	res_entry_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              pay_done_q;
	res_entry_t        head;
	logic              sel_pay;
	logic              take;
	logic              adv;

	assign head    = mem_q[rd_ptr_q];
	assign empty   = (cnt_q == '0);
	assign q_full  = (cnt_q == QCNT_W'(QDEPTH));
	assign sel_pay = head.has_pay && !pay_done_q;
	assign split   = sel_pay && head.has_st;
	assign take    = pop && !empty;
	assign adv     = take && !split;

	assign out_byte   = sel_pay ? head.pay : 8'd0;
	assign is_status  = !sel_pay;
	assign status     = sel_pay ? ST_FOUND : head.st;
	assign end_of_run = !sel_pay;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			cnt_q      <= '0;
			pay_done_q <= 1'b0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (adv)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (wr_en && !adv)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (adv && !wr_en)
				cnt_q <= cnt_q - QCNT_W'(1);
			// hold the entry after its payload half, drop it after its status half
			if (take)
				pay_done_q <= split;
		end
	end

endmodule

FILE: sv/obu_wrapped_payload_unwrap_unit.sv
// Top level of the OBU wrapped payload unwrap unit.
//
// Feed one frame byte per item on the input queue port: data_byte, with last
// high on the frame's final byte; push while full is low. The unit walks the
// OBU headers and sizes, finds the wrapper frame OBU and emits the rest of its
// payload as result items (is_status low). On the last byte one status item
// follows (is_status and end_of_run high, out_byte zero): found, not found,
// forbidden bit or malformed. Payload items of a frame are valid only if its
// status reads found.
// Results are read from the output queue port: the oldest item sits on the
// result ports while empty is low and leaves when pop is high.
// A result item is registered in the queue as its byte is accepted; with the queue empty it shows in the next cycle.
// The unit takes one byte per cycle while full is low; the front parser updates its state
// once per accepted byte. A final byte that carries both a payload byte and the status
// takes two pops from one queue entry.
// A four-entry queue parts parser and output; full rises only when the
// receiver stalls long enough to fill it, and the parser then holds.
// Reset clears the parser to expect an OBU header and empties the queue.
module obu_wrapped_payload_unwrap_unit import obu_unw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       is_status,
	output logic [1:0] status,
	output logic       end_of_run
);

	logic       accept;
	logic       wr_en;
	res_entry_t wr_entry;
	logic       at_hdr;
	logic       q_full;
	logic       split;

	// Advance the parser only when the queue has room for what this byte yields
	assign full   = q_full;
	assign accept = push && !q_full;

	obu_unw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last      (last),
		.wr_en     (wr_en),
		.wr_entry  (wr_entry),
		.at_hdr    (at_hdr)
	);

	obu_unw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_entry   (wr_entry),
		.q_full     (q_full),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.is_status  (is_status),
		.status     (status),
		.end_of_run (end_of_run),
		.split      (split)
	);

`ifndef NO_ASSERTIONS
	// A frame's last byte returns the parser to header search
	a_last_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> at_hdr)
		else $error("parser not back at header after last byte");

	// A frame's last byte always leaves a status item waiting
	a_last_queues_status: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> !empty)
		else $error("no result waiting after last byte");

	// The payload half of a combined entry is followed by its status half
	a_split_then_status: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && split) |=> (!empty && is_status && end_of_run))
		else $error("status item missing after payload half");
`endif

endmodule

FILE: tb/sv/obu_wrapped_payload_unwrap_unit_tb.sv
// Self-checking testbench for the OBU wrapped payload unwrap unit.
module obu_wrapped_payload_unwrap_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import obu_unw_pkg::*;

	// Four magic bytes that must follow the wrapper tag, first byte on top
	localparam logic [31:0] WRAP_MAGIC = 32'h4C4B_4550;

	// Receiver hold-off used to fill the result queue and stall the input side
	localparam int HOLD_CYCLES  = 150;
	// Input bytes fed by the random part
	localparam int RANDOM_BYTES = 1000;

	// One result item as it should appear on the output ports
	typedef struct packed {
		logic [7:0] data;
		logic       stat_flag;
		logic [1:0] code;
		logic       eor;
	} unwrap_item_t;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] data_byte;
	logic       last;
	logic       empty;
	logic       pop;
	logic [7:0] out_byte;
	logic       is_status;
	logic [1:0] status;
	logic       end_of_run;

	// Items the unit still owes us, oldest first
	unwrap_item_t awaited_items[$];
	// Frame under construction before it is fed
	logic [7:0]   frame_buf[$];

	int mismatches = 0;
	int fed_bytes  = 0;

	// Side behavior: tight modes drop the random gaps, hold_req asks for a long stall
	bit send_tight = 1'b0;
	bit recv_tight = 1'b0;
	bit hold_req   = 1'b0;

	// Parser state mirrored by the predictor
	phase_t      walk_ph;
	logic [7:0]  hdr_reg;
	logic [63:0] leb_acc;
	int          leb_cnt;
	logic [63:0] remain;
	logic [1:0]  verdict;

	obu_wrapped_payload_unwrap_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.last       (last),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.is_status  (is_status),
		.status     (status),
		.end_of_run (end_of_run)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Queue helpers
	// ------------------------------------------------------------------

	// Append one byte to the frame under construction
	task automatic append_byte(input logic [7:0] b);
		frame_buf = {frame_buf, b};
	endtask

	// Append one item to the awaited list
	task automatic queue_item(input logic [7:0] data, input logic stat_flag,
		input logic [1:0] code, input logic eor);
		unwrap_item_t it;
		it.data      = data;
		it.stat_flag = stat_flag;
		it.code      = code;
		it.eor       = eor;
		awaited_items = {awaited_items, it};
	endtask

	// ------------------------------------------------------------------
	// Predictor: walk the OBU structure byte by byte and queue the items
	// ------------------------------------------------------------------

	// Return to the reset view: expect a header, nothing found yet
	task automatic parser_clear();
		walk_ph = PH_HDR;
		hdr_reg = 8'h00;
		leb_acc = 64'd0;
		leb_cnt = 0;
		remain  = 64'd0;
		verdict = ST_NOTFOUND;
	endtask

	// Stop the search; everything up to the last byte is ignored
	task automatic conclude(input logic [1:0] code);
		verdict = code;
		walk_ph = PH_DONE;
	endtask

	// Enter the payload of the current OBU; only frame OBUs are searched
	task automatic open_payload(input logic sized, input logic [63:0] size);
		logic frame_obu;
		frame_obu = ((hdr_reg & HDR_TYPE_MASK) >> 3) == FRAME_OBU_TYPE;
		if (sized) begin
			remain = size;
			if (size == 64'd0)
				walk_ph = PH_HDR;
			else if (frame_obu && size >= 64'd5)
				walk_ph = PH_M0;
			else
				walk_ph = PH_SKIP;
		end else begin
			// Unsized: the OBU runs to the end of the frame
			remain = 64'd0;
			if (frame_obu)
				walk_ph = PH_M0;
			else
				conclude(ST_NOTFOUND);
		end
	endtask

	// After header (and extension): read a size field if one is present
	task automatic open_size();
		if ((hdr_reg & HDR_SIZE_PRESENT) != 8'h00) begin
			leb_acc = 64'd0;
			leb_cnt = 0;
			walk_ph = PH_LEB;
		end else begin
			open_payload(1'b0, 64'd0);
		end
	endtask

	// Status reported on the final byte, taken from where the walk stands
	function automatic logic [1:0] closing_status();
		logic sized;
		sized = (hdr_reg & HDR_SIZE_PRESENT) != 8'h00;
		case (walk_ph)
			PH_HDR:                         return ST_NOTFOUND;
			PH_EXT, PH_LEB, PH_SKIP:        return ST_MALFORMED;
			PH_EMIT:                        return sized ? ST_MALFORMED : ST_FOUND;
			PH_M0, PH_M1, PH_M2, PH_M3, PH_M4: return sized ? ST_MALFORMED : ST_NOTFOUND;
			default:                        return verdict;
		endcase
	endfunction

	// Advance the walk by one accepted byte and queue what it causes
	task automatic predict_unwrap(input logic [7:0] b, input logic lst);
		logic       ok;
		logic       sized;
		phase_t     nxt;
		sized = (hdr_reg & HDR_SIZE_PRESENT) != 8'h00;
		nxt   = PH_EMIT;
		ok    = 1'b0;
		case (walk_ph)
			PH_HDR: begin
				hdr_reg = b;
				if ((b & HDR_FORBIDDEN) != 8'h00)
					conclude(ST_FORBIDDEN);
				else if ((b & HDR_EXTENSION) != 8'h00)
					walk_ph = PH_EXT;
				else
					open_size();
			end
			PH_EXT: open_size();
			PH_LEB: begin
				leb_acc |= 64'(b & LEB_DATA_MASK) << (7 * (leb_cnt % LEB_MAX));
				if ((b & LEB_CONT) == 8'h00) begin
					// Sizes beyond the counter width are malformed
					if ((leb_acc >> LEN_BITS) != 64'd0)
						conclude(ST_MALFORMED);
					else
						open_payload(1'b1, leb_acc);
				end else begin
					leb_cnt++;
					if (leb_cnt >= LEB_MAX)
						conclude(ST_MALFORMED);
				end
			end
			PH_SKIP: begin
				if (remain != 64'd0)
					remain--;
				if (remain == 64'd0)
					walk_ph = PH_HDR;
			end
			PH_M0, PH_M1, PH_M2, PH_M3, PH_M4: begin
				case (walk_ph)
					PH_M0: begin
						ok  = (b == KEY_TAG) || (b == INTER_TAG);
						nxt = PH_M1;
					end
					PH_M1: begin
						ok  = b == WRAP_MAGIC[31:24];
						nxt = PH_M2;
					end
					PH_M2: begin
						ok  = b == WRAP_MAGIC[23:16];
						nxt = PH_M3;
					end
					PH_M3: begin
						ok  = b == WRAP_MAGIC[15:8];
						nxt = PH_M4;
					end
					default: begin
						ok  = b == WRAP_MAGIC[7:0];
						nxt = PH_EMIT;
					end
				endcase
				if (sized && remain != 64'd0)
					remain--;
				if (!ok) begin
					// Check failed: skip the rest of a sized OBU, give up on an unsized one
					if (sized)
						walk_ph = (remain != 64'd0) ? PH_SKIP : PH_HDR;
					else
						conclude(ST_NOTFOUND);
				end else if (walk_ph == PH_M4 && sized && remain == 64'd0) begin
					// Wrapper with an empty remainder
					conclude(ST_FOUND);
				end else begin
					walk_ph = nxt;
				end
			end
			PH_EMIT: begin
				queue_item(b, 1'b0, ST_FOUND, 1'b0);
				if (sized) begin
					if (remain != 64'd0)
						remain--;
					if (remain == 64'd0)
						conclude(ST_FOUND);
				end
			end
			default: ;
		endcase
		if (lst) begin
			queue_item(8'h00, 1'b1, closing_status(), 1'b1);
			parser_clear();
		end
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic log_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [7:0] got,
		input logic [7:0] want);
		if (got !== want)
			log_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	// Compare the item on the ports with the oldest one we are waiting for
	task automatic check_result();
		unwrap_item_t want;
		if (awaited_items.size() == 0) begin
			log_mismatch($sformatf("item with none awaited: out_byte %0h is_status %0b status %0d",
				out_byte, is_status, status));
		end else begin
			want = awaited_items.pop_front();
			compare_field("out_byte", out_byte, want.data);
			compare_field("is_status", 8'(is_status), 8'(want.stat_flag));
			compare_field("status", 8'(status), 8'(want.code));
			compare_field("end_of_run", 8'(end_of_run), 8'(want.eor));
		end
	endtask

	// Receiver: stall at random, hold off for a long stretch on request,
	// and check every item taken at a rising edge
	initial begin
		int stall;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				pop = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			stall = recv_tight ? 0 : $urandom_range(0, 4);
			if (stall != 0) begin
				pop = 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop = 1'b1;
			do @(posedge clk); while (empty);
			check_result();
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one byte; starts and ends at a falling edge. Keep push high
	// across back-to-back bytes, drop it only for a gap.
	task automatic send_byte(input logic [7:0] b, input logic lst);
		int gap;
		gap = send_tight ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		data_byte = b;
		last      = lst;
		push      = 1'b1;
		do @(posedge clk); while (full);
		predict_unwrap(b, lst);
		fed_bytes++;
		@(negedge clk);
	endtask

	// Feed the built frame, last marked on its final byte
	task automatic send_frame();
		int n;
		n = frame_buf.size();
		for (int i = 0; i < n; i++)
			send_byte(frame_buf[i], i == n - 1);
	endtask

	// Header byte with a random reserved bit, plus a random extension byte when ext is set
	task automatic put_header(input logic [3:0] ty, input logic ext, input logic sized);
		append_byte({1'b0, ty, ext, sized, 1'($urandom_range(0, 1))});
		if (ext)
			append_byte(8'($urandom_range(0, 255)));
	endtask

	// LEB128 size, padded with extra continuation bytes up to the 8-byte limit
	task automatic put_leb(input logic [63:0] value, input int pad);
		int n;
		int total;
		logic [7:0] g;
		n = 1;
		while (n < LEB_MAX && (value >> (7 * n)) != 64'd0)
			n++;
		total = (n + pad > LEB_MAX) ? LEB_MAX : n + pad;
		for (int i = 0; i < total; i++) begin
			g = 8'((value >> (7 * i)) & 64'h7F);
			if (i < total - 1)
				g |= LEB_CONT;
			append_byte(g);
		end
	endtask

	// Wrapper frame OBU: tag, magic, then plen payload bytes
	task automatic put_wrapper(input int plen, input logic sized);
		put_header(FRAME_OBU_TYPE, 1'($urandom_range(0, 1)), sized);
		if (sized)
			put_leb(64'(plen + 5), $urandom_range(0, 2));
		append_byte($urandom_range(0, 1) ? KEY_TAG : INTER_TAG);
		for (int i = 0; i < 4; i++)
			append_byte(WRAP_MAGIC[31 - 8 * i -: 8]);
		repeat (plen) append_byte(8'($urandom_range(0, 255)));
	endtask

	// Some other OBU, mostly harmless; now and then a broken size or a forbidden header
	task automatic put_filler();
		int          kind;
		int          plen;
		logic [3:0]  ty;
		logic [63:0] big;
		kind = $urandom_range(0, 49);
		ty   = 4'($urandom_range(0, 15));
		plen = $urandom_range(0, 6);
		if (kind == 0) begin
			// LEB128 that never terminates
			put_header(ty, 1'($urandom_range(0, 1)), 1'b1);
			repeat (LEB_MAX) append_byte(8'($urandom_range(128, 255)));
		end else if (kind < 3) begin
			// Huge size: oversized, or past the end of the frame
			big = {$urandom, $urandom};
			big = big >> $urandom_range(8, 40);
			put_header(ty, 1'($urandom_range(0, 1)), 1'b1);
			put_leb(big, 0);
			repeat (plen) append_byte(8'($urandom_range(0, 255)));
		end else if (kind == 3) begin
			append_byte(8'($urandom_range(128, 255)));
		end else begin
			put_header(ty, 1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0);
			if ((frame_buf[$] & HDR_SIZE_PRESENT) != 8'h00 ||
				(frame_buf.size() > 1 && (frame_buf[$-1] & HDR_SIZE_PRESENT) != 8'h00 &&
				(frame_buf[$-1] & HDR_EXTENSION) != 8'h00))
				put_leb(64'(plen), $urandom_range(0, 1));
			repeat (plen) append_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// Mostly well-formed frames with random content; some noise, some damage
	task automatic build_random_frame();
		int roll;
		int cut;
		frame_buf.delete();
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			repeat ($urandom_range(1, 12)) append_byte(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 3)) put_filler();
			if (roll < 88)
				put_wrapper(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
					: $urandom_range(0, 12), $urandom_range(0, 4) != 0);
			if ($urandom_range(0, 3) == 0)
				put_filler();
			roll = $urandom_range(0, 9);
			if (roll == 0 && frame_buf.size() > 0) begin
				// Flip one bit somewhere
				cut = $urandom_range(0, frame_buf.size() - 1);
				frame_buf[cut] ^= 8'(1 << $urandom_range(0, 7));
			end else if (roll == 1 && frame_buf.size() > 1) begin
				// Chop the tail off
				cut = $urandom_range(1, frame_buf.size() - 1);
				repeat (cut) void'(frame_buf.pop_back());
			end
		end
		if (frame_buf.size() == 0)
			append_byte(8'($urandom_range(0, 255)));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Header-level outcomes: forbidden bit, cut-off extension or size,
	// unsized non-frame OBU, empty sized OBU
	task automatic test_header_cases();
		frame_buf = '{8'hFF, 8'h00};
		send_frame();
		frame_buf = '{8'h34};
		send_frame();
		frame_buf = '{8'h32, 8'h85};
		send_frame();
		frame_buf = '{8'h08, 8'h00, 8'hFF};
		send_frame();
		frame_buf = '{8'h12, 8'h00};
		send_frame();
	endtask

	// Size faults: LEB128 of eight continuation bytes, size of 2^32,
	// size running past the end of the frame
	task automatic test_size_faults();
		frame_buf = '{8'h32, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
		send_frame();
		frame_buf = '{8'h32, 8'h80, 8'h80, 8'h80, 8'h80, 8'h10};
		send_frame();
		frame_buf = '{8'h32, 8'h0A, 8'h10, 8'h4C};
		send_frame();
	endtask

	// Wrapper found: empty remainder, inter tag with extension and trailing
	// bytes, unsized key wrapper to the end, and an unsized one cut short
	task automatic test_wrapper_found();
		frame_buf = '{8'h32, 8'h05, 8'h10, 8'h4C, 8'h4B, 8'h45, 8'h50, 8'hAA};
		send_frame();
		frame_buf = '{8'h36, 8'h00, 8'h08, 8'h30, 8'h4C, 8'h4B, 8'h45, 8'h50,
			8'h01, 8'h7F, 8'h80};
		send_frame();
		frame_buf = '{8'h30, 8'h10, 8'h4C, 8'h4B, 8'h45, 8'h50, 8'hFF, 8'h00};
		send_frame();
		frame_buf = '{8'h30, 8'h10, 8'h4C};
		send_frame();
	endtask

	// Long receiver stall while a long wrapper streams in: fill the queue
	task automatic test_backpressure();
		send_tight = 1'b1;
		hold_req   = 1'b1;
		frame_buf.delete();
		put_wrapper(60, 1'b1);
		send_frame();
		send_tight = 1'b0;
	endtask

	// Random frames, switching between idling and tight stretches
	task automatic test_random_frames();
		fed_bytes = 0;
		while (fed_bytes < RANDOM_BYTES) begin
			send_tight = $urandom_range(0, 5) == 0;
			recv_tight = $urandom_range(0, 5) == 0;
			build_random_frame();
			send_frame();
		end
		send_tight = 1'b0;
		recv_tight = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n    = 1'b0;
		push      = 1'b0;
		data_byte = 8'h00;
		last      = 1'b0;
		parser_clear();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_header_cases();
		test_size_faults();
		test_wrapper_found();
		test_backpressure();
		test_random_frames();

		// Drain: wait for every awaited item, then watch for strays
		push = 1'b0;
		while (awaited_items.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("obu_wrapped_payload_unwrap_unit test passed");
		else
			$display("obu_wrapped_payload_unwrap_unit test failed");
		$finish;
	end

	// Watchdog: a hung handshake ends the run
	initial begin
		#5ms;
		$display("obu_wrapped_payload_unwrap_unit test failed");
		$finish;
	end

endmodule
